@@ rtl/gyro_motion_level_macros.svh @@
`ifndef GYRO_MOTION_LEVEL_MACROS_SVH
`define GYRO_MOTION_LEVEL_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GML_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GML_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/gml_pkg.sv @@
package gml_pkg;

   localparam int CAL_COUNT_MAX_DEF = 1024;
   localparam int SAMPLE_BITS_DEF   = 16;

   localparam int DEADBAND_W    = 15;
   localparam int FULL_SCALE_W  = 16;
   localparam int ALPHA_W       = 16;
   localparam int CAL_SAMPLES_W = 11;
   localparam int LEVEL_W       = 16;
   localparam int STATUS_W      = 2;

   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [DEADBAND_W-1:0]    DEADBAND_RST    = 15'd393;
   localparam logic [FULL_SCALE_W-1:0]  FULL_SCALE_RST  = 16'd19650;
   localparam logic [ALPHA_W-1:0]       ALPHA_RST       = 16'd24622;
   localparam logic [CAL_SAMPLES_W-1:0] CAL_SAMPLES_RST = 11'd400;

   // fixed point: bias carries 8 fraction bits, filter state 16
   localparam int BIAS_FRAC  = 8;
   localparam int FILT_FRAC  = 16;
   localparam int FILT_ROUND = 32768;
   localparam int LEVEL_FRAC = 15;
   localparam int LEVEL_ONE  = 32768;
   // width of full_scale << 16 plus one bit
   localparam int LEVEL_CMP_W = FULL_SCALE_W + FILT_FRAC + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEADBAND    = 2'd0,
      CSR_FULL_SCALE  = 2'd1,
      CSR_ALPHA       = 2'd2,
      CSR_CAL_SAMPLES = 2'd3
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 2'd0,
      STAT_READ_FAILED = 2'd1,
      STAT_HALTED      = 2'd2
   } status_type;

   typedef struct packed {
      logic start;
      logic full_width;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ rtl/gml_req_if.sv @@
interface gml_req_if import gml_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          read_ok;

   modport source (output valid, output sample, output read_ok, input ready);
   modport sink (input valid, input sample, input read_ok, output ready);
endinterface

@@ rtl/gml_rsp_if.sv @@
interface gml_rsp_if import gml_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [LEVEL_W-1:0]  level;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output level, output status, input ready);
   modport sink (input valid, input level, input status, output ready);
endinterface

@@ rtl/gml_div.sv @@
`include "gyro_motion_level_macros.svh"

module gml_div import gml_pkg::*; #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 17
) (
   input  logic               clock,
   input  logic               reset,
   input  div_cmd_type        cmd,
   input  logic [DEN_W-1:0]   rem_init,
   input  logic [NUM_W-1:0]   num,
   input  logic [DEN_W-1:0]   den,
   output div_stat_type       stat,
   output logic [NUM_W-1:0]   quot
);
   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [NUM_W-1:0]  sh_ff;
   logic [DEN_W-1:0]  rem_in;
   logic [DEN_W+1:0]  trial;
   logic              take;

   // restoring step: one quotient bit per cycle, shifted into the dividend register
   assign trial  = {1'b0, rem_ff, sh_ff[NUM_W-1]} - {2'b00, den_ff};
   assign take   = !trial[DEN_W+1];
   assign rem_in = take ? trial[DEN_W-1:0] : {rem_ff[DEN_W-2:0], sh_ff[NUM_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (busy_ff) begin
            rem_ff <= rem_in;
            sh_ff  <= {sh_ff[NUM_W-2:0], take};
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end else if (cmd.start) begin
            busy_ff <= 1'b1;
            rem_ff  <= rem_init;
            sh_ff   <= num;
            den_ff  <= den;
            cnt_ff  <= cmd.full_width ? STEP_W'(NUM_W) : STEP_W'(LEVEL_FRAC);
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = sh_ff;

   `GML_ASSERT_IMPL(a_div_rem_below_den, clock, reset, busy_ff, rem_ff < den_ff, "divider remainder reached divisor")
   `GML_ASSERT_IMPL(a_div_no_restart, clock, reset, busy_ff, !cmd.start, "divider started while busy")
   `GML_ASSERT_NEXT(a_div_done_after_last, clock, reset, busy_ff && cnt_ff == STEP_W'(1), done_ff && !busy_ff, "divider did not finish after last step")

endmodule

@@ rtl/gyro_motion_level.sv @@
// Gyro motion level. The first cal_samples good samples (clamped to 1..CAL_COUNT_MAX)
// are summed with no result and their rounded mean becomes the bias; a failed read
// during calibration halts the block until reset, and from then on each item answers
// level 0, status halted. After calibration each good sample has the bias removed,
// passes a first-order low-pass with coefficient alpha (Q0.16), and its absolute value
// is mapped through the deadband to a Q1.15 level clamped to 1.0; a failed read answers
// level 0, status read failed and leaves the filter untouched. One item is worked on at
// a time. A failed or halted item goes straight to the output stage; a calibration sample
// is summed and checked against the limit, and the last one runs the shared divider over
// its full dividend width (SAMPLE_BITS + clog2(CAL_COUNT_MAX+1) + 9 steps, 36 at the
// defaults). A filtered sample skips the divider when the speed lies in the deadband or
// beyond full scale, and otherwise runs 15 steps of the same divider.
// A finished result waits in the output register while the next item is taken.
`include "gyro_motion_level_macros.svh"

module gyro_motion_level import gml_pkg::*; #(
   parameter int CAL_COUNT_MAX = CAL_COUNT_MAX_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   gml_req_if.sink              req_if,
   gml_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);
   localparam int CNT_W   = $clog2(CAL_COUNT_MAX + 1);
   localparam int LIM_W   = (CNT_W > CAL_SAMPLES_W) ? CNT_W : CAL_SAMPLES_W;
   localparam int SUM_W   = SAMPLE_BITS + CNT_W;
   localparam int NUM_W   = SUM_W + BIAS_FRAC + 1;
   localparam int BIAS_W  = SAMPLE_BITS + BIAS_FRAC;
   localparam int FILT_W  = SAMPLE_BITS + 24;
   localparam int DIFF_W  = SAMPLE_BITS + 19;
   localparam int PROD_W  = DIFF_W + ALPHA_W + 1;
   localparam int STEP_W  = PROD_W - FILT_FRAC + 1;
   localparam int SPEED_W = (SAMPLE_BITS + 17 > LEVEL_CMP_W) ? SAMPLE_BITS + 17 : LEVEL_CMP_W;
   localparam int DEN_W   = (CNT_W > FULL_SCALE_W + 1) ? CNT_W : FULL_SCALE_W + 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CAL_CHK,
      S_CAL_NUM,
      S_CAL_DIV,
      S_DIFF,
      S_MUL,
      S_FILT,
      S_ABS,
      S_CMP,
      S_LVL_DIV,
      S_DONE
   } state_type;

   state_type state_ff;

   logic [DEADBAND_W-1:0]    deadband_ff;
   logic [FULL_SCALE_W-1:0]  full_scale_ff;
   logic [ALPHA_W-1:0]       alpha_ff;
   logic [CAL_SAMPLES_W-1:0] cal_samples_ff;

   logic [CNT_W-1:0]         calib_count_ff;
   logic signed [SUM_W-1:0]  bias_sum_ff;
   logic [SUM_W-1:0]         mag_ff;
   logic signed [BIAS_W-1:0] bias_ff;
   logic signed [FILT_W-1:0] filtered_ff;
   logic signed [FILT_W-1:0] corr_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [SPEED_W-1:0]       speed_ff;
   logic                     halted_ff;
   logic                     calibrated_ff;

   logic [LEVEL_W-1:0]       pend_level_ff;
   status_type               pend_status_ff;
   logic                     rsp_valid_ff;
   logic [LEVEL_W-1:0]       rsp_level_ff;
   status_type               rsp_status_ff;

   logic                     req_take;
   logic                     rsp_free;
   logic                     rsp_load;
   logic [LIM_W-1:0]         cal_lim;
   logic signed [FILT_W-1:0] samp_w;
   logic signed [FILT_W-1:0] corr_in;
   logic signed [FILT_W-1:0] diff_full;
   logic signed [ALPHA_W:0]  alpha_s;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W:0]   rnd;
   logic signed [STEP_W-1:0] step_w;
   logic signed [FILT_W-1:0] filtered_in;
   logic [SPEED_W-1:0]       speed_in;
   logic [SPEED_W-1:0]       db_w;
   logic [SPEED_W-1:0]       fs_w;
   logic [SPEED_W-1:0]       x_w;
   logic [FULL_SCALE_W-1:0]  span;
   logic                     in_dead;
   logic                     saturate;
   logic [BIAS_W-1:0]        bias_q;
   logic signed [BIAS_W-1:0] bias_in;

   div_cmd_type              div_cmd;
   div_stat_type             div_stat;
   logic [DEN_W-1:0]         div_rem;
   logic [NUM_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;
   logic [NUM_W-1:0]         div_quot;

   assign req_take      = req_if.valid && (state_ff == S_IDLE);
   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_free      = !rsp_valid_ff || rsp_if.ready;
   assign rsp_load      = (state_ff == S_DONE) && rsp_free;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.level  = rsp_level_ff;
   assign rsp_if.status = rsp_status_ff;

   always_comb begin
      if (cal_samples_ff == '0) begin
         cal_lim = LIM_W'(1);
      end else if (LIM_W'(cal_samples_ff) > LIM_W'(CAL_COUNT_MAX)) begin
         cal_lim = LIM_W'(CAL_COUNT_MAX);
      end else begin
         cal_lim = LIM_W'(cal_samples_ff);
      end
   end

   // corrected sample in Q.16
   assign samp_w  = FILT_W'(req_if.sample);
   assign corr_in = ((samp_w <<< BIAS_FRAC) - FILT_W'(bias_ff)) <<< (FILT_FRAC - BIAS_FRAC);

   assign diff_full   = corr_ff - filtered_ff;
   assign alpha_s     = {1'b0, alpha_ff};
   assign prod_in     = diff_ff * alpha_s;
   // round half up, then floor by the filter fraction
   assign rnd         = (PROD_W+1)'(prod_ff) + (PROD_W+1)'(FILT_ROUND);
   assign step_w      = signed'(rnd[PROD_W:FILT_FRAC]);
   assign filtered_in = filtered_ff + FILT_W'(step_w);

   assign speed_in = filtered_ff[FILT_W-1] ? SPEED_W'(-filtered_ff) : SPEED_W'(filtered_ff);
   assign db_w     = SPEED_W'(deadband_ff) << FILT_FRAC;
   assign fs_w     = SPEED_W'(full_scale_ff) << FILT_FRAC;
   assign in_dead  = (speed_ff <= db_w);
   // beyond full scale the quotient would reach one: clamp without dividing
   assign saturate = (full_scale_ff <= FULL_SCALE_W'(deadband_ff)) || (speed_ff >= fs_w);
   assign x_w      = speed_ff - db_w;
   assign span     = full_scale_ff - FULL_SCALE_W'(deadband_ff);

   assign bias_q  = div_quot[BIAS_W-1:0];
   assign bias_in = bias_sum_ff[SUM_W-1] ? -signed'(bias_q) : signed'(bias_q);

   always_comb begin
      div_cmd.start      = (state_ff == S_CAL_NUM) || (state_ff == S_CMP && !in_dead && !saturate);
      div_cmd.full_width = (state_ff == S_CAL_NUM);
      if (state_ff == S_CAL_NUM) begin
         div_rem = '0;
         div_num = (NUM_W'(mag_ff) << BIAS_FRAC) + NUM_W'(calib_count_ff >> 1);
         div_den = DEN_W'(calib_count_ff);
      end else begin
         // level = (speed - db) / (2 * span), only the low quotient bits remain to shift
         div_rem = DEN_W'(x_w >> LEVEL_FRAC);
         div_num = NUM_W'(x_w[LEVEL_FRAC-1:0]) << (NUM_W - LEVEL_FRAC);
         div_den = DEN_W'({span, 1'b0});
      end
   end

   gml_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .rem_init (div_rem),
      .num      (div_num),
      .den      (div_den),
      .stat     (div_stat),
      .quot     (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         deadband_ff    <= DEADBAND_RST;
         full_scale_ff  <= FULL_SCALE_RST;
         alpha_ff       <= ALPHA_RST;
         cal_samples_ff <= CAL_SAMPLES_RST;
         calib_count_ff <= '0;
         bias_sum_ff    <= '0;
         bias_ff        <= '0;
         filtered_ff    <= '0;
         halted_ff      <= 1'b0;
         calibrated_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_DEADBAND:    deadband_ff    <= csr_wdata[DEADBAND_W-1:0];
               CSR_FULL_SCALE:  full_scale_ff  <= csr_wdata[FULL_SCALE_W-1:0];
               CSR_ALPHA:       alpha_ff       <= csr_wdata[ALPHA_W-1:0];
               CSR_CAL_SAMPLES: cal_samples_ff <= csr_wdata[CAL_SAMPLES_W-1:0];
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  pend_level_ff <= '0;
                  if (halted_ff) begin
                     pend_status_ff <= STAT_HALTED;
                     state_ff       <= S_DONE;
                  end else if (!calibrated_ff) begin
                     if (!req_if.read_ok) begin
                        halted_ff      <= 1'b1;
                        pend_status_ff <= STAT_HALTED;
                        state_ff       <= S_DONE;
                     end else begin
                        bias_sum_ff    <= bias_sum_ff + SUM_W'(req_if.sample);
                        calib_count_ff <= calib_count_ff + CNT_W'(1);
                        state_ff       <= S_CAL_CHK;
                     end
                  end else if (!req_if.read_ok) begin
                     pend_status_ff <= STAT_READ_FAILED;
                     state_ff       <= S_DONE;
                  end else begin
                     corr_ff  <= corr_in;
                     state_ff <= S_DIFF;
                  end
               end
            end
            S_CAL_CHK: begin
               mag_ff <= bias_sum_ff[SUM_W-1] ? SUM_W'(-bias_sum_ff) : SUM_W'(bias_sum_ff);
               if (LIM_W'(calib_count_ff) >= cal_lim) begin
                  state_ff <= S_CAL_NUM;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_CAL_NUM: begin
               state_ff <= S_CAL_DIV;
            end
            S_CAL_DIV: begin
               if (div_stat.done) begin
                  bias_ff       <= bias_in;
                  filtered_ff   <= '0;
                  calibrated_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_DIFF: begin
               diff_ff  <= DIFF_W'(diff_full);
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_FILT;
            end
            S_FILT: begin
               filtered_ff <= filtered_in;
               state_ff    <= S_ABS;
            end
            S_ABS: begin
               speed_ff <= speed_in;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               pend_status_ff <= STAT_OK;
               if (in_dead) begin
                  pend_level_ff <= '0;
                  state_ff      <= S_DONE;
               end else if (saturate) begin
                  pend_level_ff <= LEVEL_W'(LEVEL_ONE);
                  state_ff      <= S_DONE;
               end else begin
                  state_ff <= S_LVL_DIV;
               end
            end
            S_LVL_DIV: begin
               if (div_stat.done) begin
                  pend_level_ff <= LEVEL_W'(div_quot[LEVEL_FRAC-1:0]);
                  state_ff      <= S_DONE;
               end
            end
            S_DONE: begin
               // hold until the output register is free
               if (rsp_free) begin
                  rsp_level_ff  <= pend_level_ff;
                  rsp_status_ff <= pend_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `GML_ASSERT_IMPL(a_level_range, clock, reset, rsp_valid_ff,
      rsp_level_ff <= LEVEL_W'(LEVEL_ONE), "level above one")
   `GML_ASSERT_IMPL(a_halt_excl, clock, reset, halted_ff,
      !calibrated_ff, "halted after calibration finished")
   `GML_ASSERT_IMPL(a_halted_status, clock, reset, rsp_valid_ff && rsp_status_ff == STAT_HALTED,
      halted_ff, "halted status while running")
   `GML_ASSERT_IMPL(a_fail_status, clock, reset,
      rsp_valid_ff && rsp_status_ff == STAT_READ_FAILED,
      calibrated_ff, "read failed status before calibration")
   `GML_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
      calib_count_ff <= CNT_W'(CAL_COUNT_MAX), "calibration count beyond maximum")

endmodule
